[hdl/arpenc_pkg.sv]
// Shared types, constants and burst layout tables for the ARP reply and PPPoE encapsulation unit.
`default_nettype none

package arpenc_pkg;

   localparam int HOLD_DEPTH = 42;
   localparam int HOLD_AW = $clog2(HOLD_DEPTH);

   localparam logic [15:0] ETYPE_IPV4 = 16'h0800;
   localparam logic [15:0] ETYPE_IPV6 = 16'h86DD;
   localparam logic [15:0] ETYPE_ARP = 16'h0806;
   localparam logic [15:0] ETYPE_PPPOE_SESSION = 16'h8864;
   localparam logic [7:0] PPPOE_VER_TYPE = 8'h11;
   localparam logic [7:0] PPPOE_CODE_DATA = 8'h00;
   localparam logic [15:0] PPP_IPV4 = 16'h0021;
   localparam logic [15:0] PPP_IPV6 = 16'h0057;
   localparam logic [15:0] ARP_REPLY = 16'h0002;

   localparam logic [1:0] VERDICT_PASS = 2'd0;
   localparam logic [1:0] VERDICT_TX = 2'd1;
   localparam logic [1:0] VERDICT_REDIRECT = 2'd2;

   localparam logic [2:0] CSR_ROUTER_MAC = 3'd0;
   localparam logic [2:0] CSR_UPLINK_SRC_MAC = 3'd1;
   localparam logic [2:0] CSR_PEER_MAC = 3'd2;
   localparam logic [2:0] CSR_SESSION_ID = 3'd3;
   localparam logic [2:0] CSR_SESSION_VALID = 3'd4;
   localparam logic [2:0] CSR_UPLINK_PORT = 3'd5;

   typedef struct packed {
      logic [7:0]  data_byte;
      logic [11:0] frame_len;
      logic        in_last;
   } req_payload_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       out_last;
      logic [1:0] verdict;
      logic [7:0] dest_port;
   } rsp_payload_type;

   typedef enum logic [1:0] {
      BURST_PASS,
      BURST_ARP,
      BURST_REDIR
   } burst_kind_type;

   typedef enum logic [2:0] {
      SRC_STORE,
      SRC_ROUTER,
      SRC_PEER,
      SRC_UPSRC,
      SRC_CONST,
      SRC_SID,
      SRC_PLEN,
      SRC_PPP
   } src_sel_type;

   typedef struct packed {
      src_sel_type          sel;
      logic [HOLD_AW-1:0]   idx;
      logic [7:0]           value;
   } step_type;

   typedef struct packed {
      logic accept;
      logic rd_issue;
      logic emit;
   } dp_cmd_type;

   typedef struct packed {
      logic burst_start;
      logic burst_final;
      logic out_free;
   } dp_status_type;

   function automatic step_type burst_step(burst_kind_type kind, logic [HOLD_AW-1:0] k);
      step_type s;
      s.sel = SRC_STORE;
      s.idx = k;
      s.value = 8'h00;
      unique case (kind)
         BURST_PASS: begin
            s.sel = SRC_STORE;
            s.idx = k;
         end
         BURST_ARP: begin
            if (k < HOLD_AW'(6)) begin
               s.idx = HOLD_AW'(k + HOLD_AW'(6));
            end else if (k < HOLD_AW'(12)) begin
               s.sel = SRC_ROUTER;
               s.idx = HOLD_AW'(k - HOLD_AW'(6));
            end else if (k < HOLD_AW'(20)) begin
               s.idx = k;
            end else if (k == HOLD_AW'(20)) begin
               s.sel = SRC_CONST;
               s.value = ARP_REPLY[15:8];
            end else if (k == HOLD_AW'(21)) begin
               s.sel = SRC_CONST;
               s.value = ARP_REPLY[7:0];
            end else if (k < HOLD_AW'(28)) begin
               s.sel = SRC_ROUTER;
               s.idx = HOLD_AW'(k - HOLD_AW'(22));
            end else if (k < HOLD_AW'(32)) begin
               s.idx = HOLD_AW'(k + HOLD_AW'(10));
            end else begin
               s.idx = HOLD_AW'(k - HOLD_AW'(10));
            end
         end
         BURST_REDIR: begin
            if (k < HOLD_AW'(6)) begin
               s.sel = SRC_PEER;
               s.idx = k;
            end else if (k < HOLD_AW'(12)) begin
               s.sel = SRC_UPSRC;
               s.idx = HOLD_AW'(k - HOLD_AW'(6));
            end else begin
               case (k)
                  HOLD_AW'(12): begin
                     s.sel = SRC_CONST;
                     s.value = ETYPE_PPPOE_SESSION[15:8];
                  end
                  HOLD_AW'(13): begin
                     s.sel = SRC_CONST;
                     s.value = ETYPE_PPPOE_SESSION[7:0];
                  end
                  HOLD_AW'(14): begin
                     s.sel = SRC_CONST;
                     s.value = PPPOE_VER_TYPE;
                  end
                  HOLD_AW'(15): begin
                     s.sel = SRC_CONST;
                     s.value = PPPOE_CODE_DATA;
                  end
                  HOLD_AW'(16): begin
                     s.sel = SRC_SID;
                     s.idx = HOLD_AW'(0);
                  end
                  HOLD_AW'(17): begin
                     s.sel = SRC_SID;
                     s.idx = HOLD_AW'(1);
                  end
                  HOLD_AW'(18): begin
                     s.sel = SRC_PLEN;
                     s.idx = HOLD_AW'(0);
                  end
                  HOLD_AW'(19): begin
                     s.sel = SRC_PLEN;
                     s.idx = HOLD_AW'(1);
                  end
                  HOLD_AW'(20): begin
                     s.sel = SRC_PPP;
                     s.idx = HOLD_AW'(0);
                  end
                  default: begin
                     s.sel = SRC_PPP;
                     s.idx = HOLD_AW'(1);
                  end
               endcase
            end
         end
         default: begin
            s.sel = SRC_STORE;
            s.idx = k;
         end
      endcase
      return s;
   endfunction

endpackage

`default_nettype wire

[hdl/arpenc_ram.sv]
// Generic single-port-write, registered-read RAM.
`default_nettype none

module arpenc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 42
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

[hdl/arpenc_ctrl.sv]
// Controller state machine sequencing input transfers and header bursts.
`default_nettype none

module arpenc_ctrl import arpenc_pkg::*; (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   output logic               req_ready,
   input  wire dp_status_type status,
   output dp_cmd_type         cmd
);

   typedef enum logic [1:0] {
      ST_INPUT,
      ST_READ,
      ST_EMIT
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in = state_ff;
      req_ready = 1'b0;
      cmd = '0;
      unique case (state_ff)
         ST_INPUT: begin
            req_ready = status.out_free;
            cmd.accept = req_valid && status.out_free;
            if (cmd.accept && status.burst_start) begin
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            cmd.rd_issue = 1'b1;
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (status.out_free) begin
               cmd.emit = 1'b1;
               state_in = status.burst_final ? ST_INPUT : ST_READ;
            end
         end
         default: begin
            state_in = ST_INPUT;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_INPUT;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

[hdl/arpenc_dp.sv]
// Datapath: registers, header store, frame classification and output register.
`default_nettype none

module arpenc_dp import arpenc_pkg::*; #(
   parameter int MAX_FRAME = 2048
) (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire dp_cmd_type      cmd,
   output dp_status_type        status,
   input  wire req_payload_type req_payload,
   output logic                 rsp_valid,
   input  wire logic            rsp_ready,
   output rsp_payload_type      rsp_payload,
   input  wire logic            csr_valid,
   output logic                 csr_ready,
   input  wire logic [2:0]      csr_index,
   input  wire logic [47:0]     csr_wdata
);

   typedef enum logic [1:0] {
      MODE_COLLECT,
      MODE_PASS,
      MODE_TX,
      MODE_REDIRECT
   } mode_type;

   localparam logic [12:0] MaxFrameLim = 13'(MAX_FRAME);
   localparam logic [HOLD_AW-1:0] PosEtypeHi = HOLD_AW'(12);
   localparam logic [HOLD_AW-1:0] PosEtypeLo = HOLD_AW'(13);
   localparam logic [HOLD_AW-1:0] PosPtypeHi = HOLD_AW'(16);
   localparam logic [HOLD_AW-1:0] PosPtypeLo = HOLD_AW'(17);
   localparam logic [HOLD_AW-1:0] PosLast = HOLD_AW'(HOLD_DEPTH - 1);
   localparam logic [HOLD_AW-1:0] EthHdrLen = HOLD_AW'(14);
   localparam logic [HOLD_AW-1:0] RedirLen = HOLD_AW'(22);
   localparam logic [HOLD_AW-1:0] ArpLen = HOLD_AW'(HOLD_DEPTH);

   function automatic logic [7:0] mac_byte(logic [47:0] mac, logic [HOLD_AW-1:0] idx);
      logic [7:0] b;
      case (idx)
         HOLD_AW'(0): b = mac[47:40];
         HOLD_AW'(1): b = mac[39:32];
         HOLD_AW'(2): b = mac[31:24];
         HOLD_AW'(3): b = mac[23:16];
         HOLD_AW'(4): b = mac[15:8];
         default:     b = mac[7:0];
      endcase
      return b;
   endfunction

   logic [47:0]        router_mac_ff, upsrc_mac_ff, peer_mac_ff;
   logic [15:0]        session_id_ff;
   logic               session_valid_ff;
   logic [7:0]         uplink_port_ff;

   mode_type           mode_ff, mode_in;
   logic [HOLD_AW-1:0] pos_ff, pos_in;
   logic [11:0]        held_len_ff;
   logic [7:0]         et_hi_ff, pt_hi_ff, pt_lo_ff;
   logic               is_v6_ff;
   burst_kind_type     kind_ff, kind_in;
   logic [HOLD_AW-1:0] len_ff, len_in;
   logic [HOLD_AW-1:0] k_ff;
   logic               burst_last_ff;
   logic               rsp_valid_ff;
   rsp_payload_type    rsp_ff, rsp_in;
   logic               load;

   logic [11:0]        hl;
   logic [15:0]        etype;
   logic               len_ok, is_ip, arp_keep, redir, at_type, at_end, collecting;
   logic               out_free;
   logic [7:0]         ram_rdata;
   step_type           step;
   logic [7:0]         burst_byte;
   logic [11:0]        plen;
   logic [15:0]        ppp;
   logic [1:0]         vd;

   assign collecting = (mode_ff == MODE_COLLECT);
   assign hl = (pos_ff == '0) ? req_payload.frame_len : held_len_ff;
   assign etype = {et_hi_ff, req_payload.data_byte};
   assign len_ok = (hl >= 12'd14) && ({1'b0, hl} <= MaxFrameLim);
   assign is_ip = (etype == ETYPE_IPV4) || (etype == ETYPE_IPV6);
   assign arp_keep = len_ok && (etype == ETYPE_ARP) && (hl >= 12'd42);
   assign redir = len_ok && is_ip && session_valid_ff;
   assign at_type = (pos_ff == PosEtypeLo);
   assign at_end = (pos_ff == PosLast);

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign status.out_free = out_free;
   assign status.burst_start = collecting
                               && ((at_type && !arp_keep) || at_end || req_payload.in_last);
   assign status.burst_final = (k_ff == HOLD_AW'(len_ff - HOLD_AW'(1)));

   assign csr_ready = 1'b1;

   arpenc_ram #(
      .WIDTH(8),
      .DEPTH(HOLD_DEPTH)
   ) u_store (
      .clock  (clock),
      .wr_en  (cmd.accept && collecting),
      .wr_addr(pos_ff),
      .wr_data(req_payload.data_byte),
      .rd_en  (cmd.rd_issue),
      .rd_addr(step.idx),
      .rd_data(ram_rdata)
   );

   assign step = burst_step(kind_ff, k_ff);
   assign plen = held_len_ff - 12'd12;
   assign ppp = is_v6_ff ? PPP_IPV6 : PPP_IPV4;

   always_comb begin
      case (step.sel)
         SRC_STORE:  burst_byte = ram_rdata;
         SRC_ROUTER: burst_byte = mac_byte(router_mac_ff, step.idx);
         SRC_PEER:   burst_byte = mac_byte(peer_mac_ff, step.idx);
         SRC_UPSRC:  burst_byte = mac_byte(upsrc_mac_ff, step.idx);
         SRC_SID:    burst_byte = (step.idx == '0) ? session_id_ff[15:8] : session_id_ff[7:0];
         SRC_PLEN:   burst_byte = (step.idx == '0) ? {4'h0, plen[11:8]} : plen[7:0];
         SRC_PPP:    burst_byte = (step.idx == '0) ? ppp[15:8] : ppp[7:0];
         default:    burst_byte = step.value;
      endcase
   end

   always_comb begin
      mode_in = mode_ff;
      pos_in = pos_ff;
      kind_in = BURST_PASS;
      len_in = HOLD_AW'(pos_ff + HOLD_AW'(1));
      if (at_type && !arp_keep) begin
         kind_in = redir ? BURST_REDIR : BURST_PASS;
         len_in = redir ? RedirLen : EthHdrLen;
      end else if (at_end) begin
         kind_in = ({pt_hi_ff, pt_lo_ff} == ETYPE_IPV4) ? BURST_ARP : BURST_PASS;
         len_in = ArpLen;
      end
      if (cmd.accept) begin
         if (req_payload.in_last) begin
            mode_in = MODE_COLLECT;
            pos_in = '0;
         end else if (collecting) begin
            pos_in = HOLD_AW'(pos_ff + HOLD_AW'(1));
            if (at_type && !arp_keep) begin
               mode_in = redir ? MODE_REDIRECT : MODE_PASS;
            end else if (at_end) begin
               mode_in = (kind_in == BURST_ARP) ? MODE_TX : MODE_PASS;
            end
         end
      end
   end

   always_comb begin
      rsp_in = rsp_ff;
      load = 1'b0;
      vd = VERDICT_PASS;
      if (cmd.accept && !collecting) begin
         load = 1'b1;
         case (mode_ff)
            MODE_TX:       vd = VERDICT_TX;
            MODE_REDIRECT: vd = VERDICT_REDIRECT;
            default:       vd = VERDICT_PASS;
         endcase
         rsp_in.out_byte = req_payload.data_byte;
         rsp_in.out_last = req_payload.in_last;
      end else if (cmd.emit) begin
         load = 1'b1;
         case (kind_ff)
            BURST_ARP:   vd = VERDICT_TX;
            BURST_REDIR: vd = VERDICT_REDIRECT;
            default:     vd = VERDICT_PASS;
         endcase
         rsp_in.out_byte = burst_byte;
         rsp_in.out_last = burst_last_ff && status.burst_final;
      end
      if (load) begin
         rsp_in.verdict = vd;
         rsp_in.dest_port = (vd == VERDICT_REDIRECT) ? uplink_port_ff : 8'h00;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         router_mac_ff <= '0;
         upsrc_mac_ff <= '0;
         peer_mac_ff <= '0;
         session_id_ff <= '0;
         session_valid_ff <= 1'b0;
         uplink_port_ff <= '0;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_ROUTER_MAC:     router_mac_ff <= csr_wdata;
            CSR_UPLINK_SRC_MAC: upsrc_mac_ff <= csr_wdata;
            CSR_PEER_MAC:       peer_mac_ff <= csr_wdata;
            CSR_SESSION_ID:     session_id_ff <= csr_wdata[15:0];
            CSR_SESSION_VALID:  session_valid_ff <= csr_wdata[0];
            CSR_UPLINK_PORT:    uplink_port_ff <= csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_COLLECT;
         pos_ff <= '0;
         held_len_ff <= '0;
         rsp_valid_ff <= 1'b0;
         k_ff <= '0;
      end else begin
         mode_ff <= mode_in;
         pos_ff <= pos_in;
         rsp_valid_ff <= load || (rsp_valid_ff && !rsp_ready);
         if (cmd.accept && collecting && (pos_ff == '0)) begin
            held_len_ff <= req_payload.frame_len;
         end
         if (cmd.accept && status.burst_start) begin
            k_ff <= '0;
         end else if (cmd.emit) begin
            k_ff <= HOLD_AW'(k_ff + HOLD_AW'(1));
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
      if (cmd.accept && collecting) begin
         if (pos_ff == PosEtypeHi) begin
            et_hi_ff <= req_payload.data_byte;
         end
         if (pos_ff == PosPtypeHi) begin
            pt_hi_ff <= req_payload.data_byte;
         end
         if (pos_ff == PosPtypeLo) begin
            pt_lo_ff <= req_payload.data_byte;
         end
         if (at_type) begin
            is_v6_ff <= (etype == ETYPE_IPV6);
         end
      end
      if (cmd.accept && status.burst_start) begin
         kind_ff <= kind_in;
         len_ff <= len_in;
         burst_last_ff <= req_payload.in_last;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

`ifndef NO_ASSERTIONS
   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> out_free)
      else $error("Burst byte issued while the output register is occupied.");

   a_read_in_range: assert property (@(posedge clock) disable iff (reset)
      cmd.rd_issue |-> (k_ff < len_ff))
      else $error("Burst step runs past the burst length.");

   a_collect_pos: assert property (@(posedge clock) disable iff (reset)
      collecting |-> (pos_ff < ArpLen))
      else $error("Header position left the header store while collecting.");

   a_stream_out: assert property (@(posedge clock) disable iff (reset)
      (cmd.accept && !collecting) |=> rsp_valid_ff)
      else $error("Streamed byte did not reach the output register.");

   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(cmd.accept && (cmd.emit || cmd.rd_issue)))
      else $error("Input transfer taken during a burst.");
`endif

endmodule

`default_nettype wire

[hdl/arp_reply_pppoe_encap_unit.sv]
// Top level of the ARP reply and PPPoE session encapsulation unit.
`default_nettype none

// Frames enter one byte per transfer. The first 14 bytes (42 for an ARP frame) are held in a
// small header RAM until the ethertype is known, one cycle per byte while the output is free.
// The held header then leaves as a burst; each byte is fetched through the RAM's registered
// read port in a read state and sent in an emit state. An encapsulation burst is 22 bytes, an
// ARP reply 42 and an unclassified header 14 or 42, or the whole frame if shorter. The rest
// streams at one cycle per byte while the output side keeps taking transfers. Configuration
// writes are accepted every cycle and should only be made while no frame is in flight.
module arp_reply_pppoe_encap_unit import arpenc_pkg::*; #(
   parameter int MAX_FRAME = 2048
) (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_valid,
   output logic                 req_ready,
   input  wire req_payload_type req_payload,
   output logic                 rsp_valid,
   input  wire logic            rsp_ready,
   output rsp_payload_type      rsp_payload,
   input  wire logic            csr_valid,
   output logic                 csr_ready,
   input  wire logic [2:0]      csr_index,
   input  wire logic [47:0]     csr_wdata
);

   dp_cmd_type    cmd;
   dp_status_type status;

   arpenc_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .status   (status),
      .cmd      (cmd)
   );

   arpenc_dp #(
      .MAX_FRAME(MAX_FRAME)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .req_payload(req_payload),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_payload(rsp_payload),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

endmodule

`default_nettype wire
